[hdl/sbh_pkg.sv]
// shared types and constants for the string bucket hash core
package sbh_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int SIZE_W     = 31;
    localparam int CNT_W      = $clog2(WORD_W);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
    localparam logic [BYTE_W-1:0] KEY_END    = '0;

    // one multiply-accumulate job handed from front to back
    typedef struct packed {
        logic              term;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] pos;
    } t_op;

endpackage

[hdl/sbh_front.sv]
// front end: takes key bytes, packs them and issues multiply-accumulate jobs
module sbh_front
    import sbh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_full,
    output logic              o_push,
    output t_op               o_push_op
);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] r_pos;
    logic [WORD_W-1:0] n_word;
    logic              n_term;
    logic              n_accept;

    assign o_ready  = !i_full;
    assign n_accept = i_valid && !i_full;
    assign n_term   = (i_byte == KEY_END);
    assign n_word   = {r_word[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}}
                    | {{(WORD_W-BYTE_W){i_byte[BYTE_W-1]}}, i_byte};

    assign o_push         = n_accept && (n_term || (r_pos[1:0] == 2'b00));
    assign o_push_op.term = n_term;
    assign o_push_op.word = n_term ? r_word : n_word;
    assign o_push_op.pos  = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_pos  <= WORD_W'(1);
        end else if (n_accept) begin
            if (n_term) begin
                r_word <= '0;
                r_pos  <= WORD_W'(1);
            end else begin
                r_word <= n_word;
                r_pos  <= r_pos + WORD_W'(1);
            end
        end
    end

endmodule

[hdl/sbh_queue.sv]
// small job queue between front and back
module sbh_queue
    import sbh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_push_op,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_full,
    output logic o_empty
);

    t_op                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                n_push;
    logic                n_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign n_push  = i_push && !o_full;
    assign n_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (n_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (n_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (n_push && !n_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (n_pop && !n_push) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

[hdl/sbh_back.sv]
// back end: multiply-accumulate, magnitude and bit-serial modulo
module sbh_back
    import sbh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  t_op               i_op,
    output logic              o_pop,
    input  logic [SIZE_W-1:0] i_table_size,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SIZE_W-1:0] o_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MAG,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state            r_state;
    logic [WORD_W-1:0] r_prod;
    logic              r_term;
    logic [WORD_W-1:0] r_sum;
    logic [WORD_W-1:0] r_dvd;
    logic [SIZE_W-1:0] r_dvs;
    logic [SIZE_W-1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [SIZE_W-1:0] r_data;
    logic              r_valid;

    logic [WORD_W-1:0] n_prod;
    logic [WORD_W-1:0] n_shift;
    logic [WORD_W:0]   n_diff;
    logic [SIZE_W-1:0] n_rem;

    assign n_prod  = WORD_W'(i_op.word * i_op.pos);
    assign n_shift = {r_rem, r_dvd[WORD_W-1]};
    assign n_diff  = {1'b0, n_shift} - {2'b00, r_dvs};
    assign n_rem   = n_diff[WORD_W] ? n_shift[SIZE_W-1:0] : n_diff[SIZE_W-1:0];

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
            r_valid <= 1'b0;
            r_term  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_prod  <= n_prod;
                        r_term  <= i_op.term;
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    r_sum   <= r_sum + r_prod;
                    r_state <= r_term ? ST_MAG : ST_IDLE;
                end
                ST_MAG: begin
                    r_dvd   <= r_sum[WORD_W-1] ? (WORD_W'(0) - r_sum) : r_sum;
                    r_dvs   <= i_table_size;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_sum   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(WORD_W-1)) begin
                        r_data  <= (r_dvs == '0) ? '0 : n_rem;
                        r_valid <= 1'b1;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[hdl/string_bucket_hash_core.sv]
// top level of the string bucket hash core
// Key bytes stream in one per cycle while the job queue is not full; a zero
// byte ends the key and produces one bucket index, the magnitude of the
// signed 32-bit hash sum modulo table_size (0 when table_size is 0). Every
// fourth byte and the terminator queue a multiply-accumulate job, and a
// 4-entry job queue lets the front keep taking bytes meanwhile. A terminator
// holds the back end through multiply and accumulate, the magnitude, the
// one-bit-per-cycle restoring divider and presenting the result, plus any
// wait on the output. table_size resets to 1024; the user must write it
// only while no key is in progress, and the block does not enforce it.
module string_bucket_hash_core
    import sbh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] key_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [30:0] bucket_index, [31] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data        // [30:0] table_size
);

    logic [SIZE_W-1:0] r_table_size;
    logic              w_push;
    t_op               w_push_op;
    logic              w_pop;
    t_op               w_op;
    logic              w_full;
    logic              w_empty;
    logic [SIZE_W-1:0] w_bucket;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {1'b0, w_bucket};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_table_size <= i_cfg_data[SIZE_W-1:0];
        end
    end

    sbh_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_push_op (w_push_op)
    );

    sbh_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_op (w_push_op),
        .i_pop     (w_pop),
        .o_op      (w_op),
        .o_full    (w_full),
        .o_empty   (w_empty)
    );

    sbh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_op         (w_op),
        .o_pop        (w_pop),
        .i_table_size (r_table_size),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (w_bucket)
    );

endmodule

[hdl/sbh_checker.sv]
// port-level checks for the string bucket hash core, with bind
module sbh_checker
    import sbh_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [31:0] i_cfg_data
);

    logic [SIZE_W-1:0] r_size;

    // shadow of the table size as seen on the config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_size <= i_cfg_data[SIZE_W-1:0];
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tdata[31])
        else $error("pad bit set");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((r_size == '0) && (o_m_axis_tdata[30:0] == '0)) ||
            ((r_size != '0) && (o_m_axis_tdata[30:0] < r_size)))
        else $error("bucket index out of range");

endmodule

bind string_bucket_hash_core sbh_checker u_sbh_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready),
    .i_cfg_data      (i_cfg_data)
);

[tb/string_bucket_hash_core_tb.sv]
// self-checking testbench for the string bucket hash core
module string_bucket_hash_core_tb;
    import sbh_pkg::*;

    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_BYTES  = 650;

    typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN, SINK_SPARSE} t_sink_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;     // [7:0] key_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;          // [30:0] bucket_index, [31] zero
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;         // [30:0] table_size

    // hash state mirrored from the accepted byte stream
    logic [WORD_W-1:0] key_word = '0;
    logic [WORD_W-1:0] key_sum = '0;
    logic [WORD_W-1:0] key_pos = 32'd1;
    logic [SIZE_W-1:0] bucket_count = SIZE_RESET;
    logic [SIZE_W-1:0] pending_buckets[$];

    int         errors = 0;
    int         bytes_sent = 0;
    int         burst_left = 0;
    int         max_gap = 0;
    int         hold_cycles = 0;
    int         sink_cycle = 0;
    t_sink_mode sink_mode = SINK_ALWAYS;

    string_bucket_hash_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic void absorb_key_byte(input logic [7:0] ch);
        logic [WORD_W-1:0] ext;
        logic [WORD_W-1:0] mag;
        if (ch == KEY_END) begin
            key_sum = key_sum + key_word * key_pos;
            mag = key_sum[WORD_W-1] ? -key_sum : key_sum;
            if (bucket_count == '0) begin
                pending_buckets.push_back('0);
            end else begin
                pending_buckets.push_back(SIZE_W'(mag % {1'b0, bucket_count}));
            end
            key_word = '0;
            key_sum  = '0;
            key_pos  = 32'd1;
        end else begin
            ext = {{24{ch[7]}}, ch};
            key_word = (key_word << 8) | ext;
            if (key_pos[1:0] == 2'b00) begin
                key_sum = key_sum + key_word * key_pos;
            end
            key_pos = key_pos + 32'd1;
        end
    endfunction

    // result side: check every transaction, then pick the next ready value
    always @(posedge i_clk) begin : bucket_sink
        logic [SIZE_W-1:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_buckets.size() == 0) begin
                $error("bucket_index: none expected, got %0d", o_m_axis_tdata[SIZE_W-1:0]);
                errors++;
            end else begin
                want = pending_buckets.pop_front();
                if (o_m_axis_tdata[SIZE_W-1:0] != want) begin
                    $error("bucket_index: expected %0d, got %0d",
                           want, o_m_axis_tdata[SIZE_W-1:0]);
                    errors++;
                end
            end
        end
        sink_cycle++;
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_m_axis_tready <= 1'b0;
        end else begin
            case (sink_mode)
                SINK_ALWAYS:  i_m_axis_tready <= 1'b1;
                SINK_RANDOM:  i_m_axis_tready <= ($urandom_range(0, 1) != 0);
                SINK_PATTERN: i_m_axis_tready <= ((sink_cycle % 7) < 4);
                default:      i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic push_key_byte(input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(0, max_gap);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        do @(posedge i_clk); while (!o_s_axis_tready);
        absorb_key_byte(ch);
        bytes_sent++;
    endtask

    task automatic push_key(input logic [7:0] chars[$]);
        foreach (chars[i]) push_key_byte(chars[i]);
        push_key_byte(KEY_END);
    endtask

    task automatic push_random_key();
        int         len;
        logic [7:0] ch;
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = $urandom_range(16, 40);
            default: len = $urandom_range(1, 12);
        endcase
        repeat (len) begin
            case ($urandom_range(0, 5))
                0:       ch = 8'($urandom_range(128, 255));
                1:       ch = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h01;
                default: ch = 8'($urandom_range(1, 255));
            endcase
            push_key_byte(ch);
        end
        push_key_byte(KEY_END);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_buckets.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_table_size(input logic [SIZE_W-1:0] size);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= {1'b0, size};
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        bucket_count = size;
    endtask

    task automatic test_directed_keys();
        logic [7:0] chars[$];
        sink_mode = SINK_ALWAYS;
        max_gap = 0;
        push_key_byte(KEY_END);
        chars = '{8'h01};
        push_key(chars);
        chars = '{8'h80};
        push_key(chars);
        chars = '{8'h7F, 8'hFF, 8'hFF, 8'hFF};
        push_key(chars);
        chars = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48};
        push_key(chars);
    endtask

    task automatic test_table_sizes();
        logic [SIZE_W-1:0] sizes[$];
        logic [WORD_W-1:0] inv;
        logic [WORD_W-1:0] word4;
        logic [7:0]        chars[$];
        bit                found;
        sink_mode = SINK_RANDOM;
        max_gap = 3;
        sizes = '{SIZE_W'(1), SIZE_W'(0), {SIZE_W{1'b1}}, SIZE_W'(3), SIZE_RESET};
        foreach (sizes[i]) begin
            write_table_size(sizes[i]);
            repeat (3) push_random_key();
        end
        // five-byte key whose sum lands on 0x80000000: 1540*w4 + 6*b5 == 2^31
        write_table_size({SIZE_W{1'b1}});
        inv = 32'd385;
        repeat (5) inv = inv * (32'd2 - 32'd385 * inv);
        found = 1'b0;
        for (int c = 1; c < 64 && !found; c++) begin
            word4 = ((32'h2000_0000 - 32'(3 * c)) * inv) & 32'h3FFF_FFFF;
            if (word4[7:0] != 0 && !word4[7] && word4[15:8] != 0 && !word4[15]
                    && word4[23:16] != 0 && !word4[23]) begin
                found = 1'b1;
                chars = '{{2'b01, word4[29:24]}, word4[23:16], word4[15:8], word4[7:0],
                          8'(2 * c)};
            end
        end
        if (found) push_key(chars);
        write_table_size(SIZE_W'(3));
        if (found) push_key(chars);
    endtask

    task automatic test_backpressure();
        write_table_size(SIZE_W'(97));
        sink_mode = SINK_ALWAYS;
        max_gap = 0;
        hold_cycles = 400;
        repeat (16) push_random_key();
        drain_results();
    endtask

    task automatic test_random_keys();
        logic [SIZE_W-1:0] size;
        while (bytes_sent < RANDOM_BYTES) begin
            case ($urandom_range(0, 3))
                0:       size = SIZE_W'($urandom_range(1, 16));
                1:       size = SIZE_W'($urandom());
                default: size = SIZE_W'($urandom_range(1, 5000));
            endcase
            write_table_size(size);
            max_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            sink_mode = t_sink_mode'($urandom_range(0, 3));
            repeat ($urandom_range(6, 15)) push_random_key();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_keys();
        test_table_sizes();
        test_backpressure();
        test_random_keys();
        drain_results();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[string_bucket_hash_core.f]
hdl/sbh_pkg.sv
hdl/sbh_front.sv
hdl/sbh_queue.sv
hdl/sbh_back.sv
hdl/string_bucket_hash_core.sv
hdl/sbh_checker.sv
tb/string_bucket_hash_core_tb.sv
